@@ design/sbda_pkg.sv @@
// shared constants and controller/datapath command and status types
`default_nettype none

package sbda_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam int         BCD_W       = 4;

    typedef struct packed {
        logic load;      // capture a new value, clear the digit register
        logic conv;      // one shift-and-adjust step of the binary to bcd conversion
        logic dshift;    // drop the top digit, move the next one up
        logic sel_sign;  // drive the minus character instead of the top digit
    } t_dp_cmd;

    typedef struct packed {
        logic neg;
        logic top_zero;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ design/sbda_if.sv @@
// stream interfaces for the input value and the output characters
`default_nettype none

interface sbda_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

@@ design/sbda_datapath.sv @@
// magnitude and bcd digit registers with the shift-add-3 conversion step
`default_nettype none

module sbda_datapath
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    input  wire t_dp_cmd                      i_cmd,
    output t_dp_sts                           o_sts,
    output logic [7:0]                        o_char
);

    localparam int NDIG  = (VALUE_BITS * 3) / 10 + 1;
    localparam int BCD_N = NDIG * BCD_W;

    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [BCD_N-1:0]      r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [BCD_N-1:0]      adj;
    logic [BCD_W-1:0]      top;
    logic [VALUE_BITS-1:0] raw;

    assign raw = i_value;
    assign top = r_bcd[BCD_N-1 -: BCD_W];

    // digits above four get three added before the shift doubles them
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*BCD_W +: BCD_W] >= 4'd5) begin
                adj[d*BCD_W +: BCD_W] = r_bcd[d*BCD_W +: BCD_W] + 4'd3;
            end else begin
                adj[d*BCD_W +: BCD_W] = r_bcd[d*BCD_W +: BCD_W];
            end
        end
    end

    always_comb begin
        n_mag = r_mag;
        n_bcd = r_bcd;
        n_neg = r_neg;
        if (i_cmd.load) begin
            n_neg = raw[VALUE_BITS-1];
            // the most negative value negates to itself, which is the right magnitude
            n_mag = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
            n_bcd = '0;
        end else if (i_cmd.conv) begin
            n_bcd = {adj[BCD_N-2:0], r_mag[VALUE_BITS-1]};
            n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
        end else if (i_cmd.dshift) begin
            n_bcd = {r_bcd[BCD_N-BCD_W-1:0], {BCD_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    assign o_sts.neg      = r_neg;
    assign o_sts.top_zero = (top == '0);
    assign o_char         = i_cmd.sel_sign ? ASCII_MINUS : (ASCII_ZERO + {4'd0, top});

endmodule

`default_nettype wire

@@ design/sbda_ctrl.sv @@
// controller: conversion bit count, leading zero skip and character emission
`default_nettype none

module sbda_ctrl
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output logic         o_last,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    localparam int NDIG = (VALUE_BITS * 3) / 10 + 1;
    localparam int BW   = $clog2(VALUE_BITS);
    localparam int LW   = $clog2(NDIG + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [BW-1:0] r_bits, n_bits;
    logic [LW-1:0] r_left, n_left;
    logic          one_left;

    assign one_left = (r_left == LW'(1));

    always_comb begin
        n_state      = r_state;
        n_bits       = r_bits;
        n_left       = r_left;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_last       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_bits     = BW'(VALUE_BITS - 1);
                    n_left     = LW'(NDIG);
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_bits     = r_bits - BW'(1);
                if (r_bits == '0) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // zero keeps its last digit
                if (i_sts.top_zero && !one_left) begin
                    o_cmd.dshift = 1'b1;
                    n_left       = r_left - LW'(1);
                end else if (i_sts.neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SIGN: begin
                o_out_valid    = 1'b1;
                o_cmd.sel_sign = 1'b1;
                if (i_out_ready) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                o_last      = one_left;
                if (i_out_ready) begin
                    if (one_left) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.dshift = 1'b1;
                        n_left       = r_left - LW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bits  <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
            r_left  <= n_left;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a character is pending");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("digit count ran out during emission");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("block not idle after the final character");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CONV) && (r_bits == BW'(VALUE_BITS - 1)))
        else $error("accepted value did not start a conversion");

endmodule

`default_nettype wire

@@ design/signed_binary_to_decimal_ascii_unit.sv @@
// top level: signed integer in, decimal ascii characters out
//
// Input channel i_in carries one signed two's-complement value per beat.
// Output channel o_out carries one ascii character per beat, most significant
// first: '-' for a negative value, then the digits without leading zeros;
// last is high on the final character. Zero gives the single character '0'.
// One value is converted at a time; i_in.ready is high only while idle.
// Per value: an accept, then the shift-add-3 conversion (one magnitude bit
// per cycle), then the leading zero digits are dropped, then the characters
// are emitted one per beat.
// When the receiver holds o_out.ready low the pending character and last
// stay on the port until taken. A synchronous reset (i_rst_n low) returns
// the controller to idle and drops any conversion in progress.
`default_nettype none

module signed_binary_to_decimal_ascii_unit
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbda_in_if.sink    i_in,
    sbda_out_if.source o_out
);

    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic [7:0] char_code;

    sbda_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_last      (o_out.last),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sbda_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_value (i_in.value),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_char  (char_code)
    );

    assign o_out.char_code = char_code;

endmodule

`default_nettype wire

@@ tb/sv/sbda_text_checker.sv @@
// checker: predicts the decimal text of every accepted value and compares the character beats
module sbda_text_checker
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [VALUE_BITS-1:0] i_in_value,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [7:0]            i_out_char,
    input  wire logic                  i_out_last,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_text_beat;

    t_text_beat expected_text[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_beats   = 0;
    end

    // decimal text of one value, sign first, most significant digit first
    function automatic void queue_decimal_text(logic [VALUE_BITS-1:0] raw);
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] rem;
        logic [7:0]            digits [0:19];
        int                    n;
        n = 0;
        // unsigned negate keeps the most negative value exact
        mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
        do begin
            rem       = mag % 10;
            digits[n] = ASCII_ZERO + rem[7:0];
            mag       = mag / 10;
            n++;
        end while (mag != 0);
        if (raw[VALUE_BITS-1])
            expected_text.push_back('{code: ASCII_MINUS, last: 1'b0});
        for (int k = n - 1; k >= 0; k--)
            expected_text.push_back('{code: digits[k], last: (k == 0)});
    endfunction

    always @(posedge i_clk) begin
        t_text_beat want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                queue_decimal_text(i_in_value);
            if (i_out_valid && i_out_ready) begin
                o_beats++;
                if (expected_text.size() == 0) begin
                    o_errors++;
                    $display("%0t: beat with nothing expected, got char %0d last %0b",
                             $time, i_out_char, i_out_last);
                end else begin
                    want = expected_text.pop_front();
                    if (i_out_char !== want.code) begin
                        o_errors++;
                        $display("%0t: char mismatch, expected %0d got %0d",
                                 $time, want.code, i_out_char);
                    end
                    if (i_out_last !== want.last) begin
                        o_errors++;
                        $display("%0t: last mismatch, expected %0b got %0b",
                                 $time, want.last, i_out_last);
                    end
                end
            end
            o_pending = expected_text.size();
        end
    end

endmodule

@@ tb/sv/signed_binary_to_decimal_ascii_unit_tb.sv @@
// testbench top: value stimulus, output stalls and the verdict for the decimal ascii unit
module signed_binary_to_decimal_ascii_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS    = 32;
    localparam int RANDOM_VALUES = 290;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_OFF_LEN  = 400;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   values_sent;
    int   negatives_sent;
    int   mismatches;
    int   chars_pending;
    int   beats_seen;
    logic hold_off;
    int   burst_left;

    sbda_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
    sbda_out_if                           out_ch ();

    signed_binary_to_decimal_ascii_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    sbda_text_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_in_ready (in_ch.ready),
        .i_in_value (in_ch.value),
        .i_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_out_char (out_ch.char_code),
        .i_out_last (out_ch.last),
        .o_errors   (mismatches),
        .o_pending  (chars_pending),
        .o_beats    (beats_seen)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("signed_binary_to_decimal_ascii_unit test failed");
        $finish;
    end

    // receiver: stall pattern rotates through four modes, plus one long hold-off
    initial begin
        int mode;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            mode = (cycle_count / 97) % 4;
            case (mode)
                0: out_ch.ready <= !hold_off;
                1: out_ch.ready <= !hold_off && ($urandom_range(0, 1) == 1);
                2: out_ch.ready <= !hold_off && ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= !hold_off && cycle_count[1];
            endcase
        end
    end

    initial begin
        hold_off <= 1'b0;
        wait (values_sent >= 120);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] pow10 [0:9];
        logic [VALUE_BITS-1:0] v;
        pow10[0] = 1;
        for (int k = 1; k < 10; k++) pow10[k] = pow10[k-1] * 10;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 200);
            // digit-count boundaries
            3: v = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
            4: v = $urandom >> $urandom_range(0, 31);
            default: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
        endcase
        if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
        return v;
    endfunction

    // one beat on the input channel, then maybe a gap between bursts
    task automatic send_value(logic [VALUE_BITS-1:0] v);
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        values_sent++;
        if (v[VALUE_BITS-1]) negatives_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25)
                                                     : $urandom_range(0, 6);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [VALUE_BITS-1:0] directed [] = '{
            32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
            -32'sd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
            32'd1000000000, 32'd999999999, -32'sd999999999, -32'sd1000000000,
            32'd1234567890, -32'sd5, 32'h5555_5555, 32'hAAAA_AAAA,
            32'd2147483640, -32'sd7
        };
        values_sent    = 0;
        negatives_sent = 0;
        burst_left     = 0;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_value(directed[i]);
        repeat (RANDOM_VALUES) send_value(pick_value());
        if (burst_left > 0 || in_ch.valid) in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (chars_pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("converted %0d values (%0d negative), checked %0d character beats",
                 values_sent, negatives_sent, beats_seen);
        if (mismatches == 0 && chars_pending == 0) begin
            $display("signed_binary_to_decimal_ascii_unit test passed");
        end else begin
            $display("%0d mismatches, %0d characters still expected",
                     mismatches, chars_pending);
            $display("signed_binary_to_decimal_ascii_unit test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/sbda_pkg.sv
design/sbda_if.sv
design/sbda_datapath.sv
design/sbda_ctrl.sv
design/signed_binary_to_decimal_ascii_unit.sv
tb/sv/sbda_text_checker.sv
tb/sv/signed_binary_to_decimal_ascii_unit_tb.sv
